// ===== hdl/ansi_escape_command_parser_macros.svh =====
// Assertion macros for the checker file of the escape parser.
`ifndef ANSI_ESCAPE_COMMAND_PARSER_MACROS_SVH
`define ANSI_ESCAPE_COMMAND_PARSER_MACROS_SVH

// Property checked on the rising clock, ignored while reset is held.
`define ACP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock, reset included.
`define ACP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/acp_pkg.sv =====
// Shared types and constants of the escape sequence command parser.
package acp_pkg;

    // Default width of each CSI parameter
    localparam int unsigned PARAM_BITS_DEF = 16;

    // Command codes on the result stream
    localparam logic [2:0] CMD_PUT_CHAR   = 3'd0;
    localparam logic [2:0] CMD_SET_CURSOR = 3'd1;
    localparam logic [2:0] CMD_MOVE       = 3'd2;
    localparam logic [2:0] CMD_CLEAR_HOME = 3'd3;
    localparam logic [2:0] CMD_CLEAR_EOS  = 3'd4;
    localparam logic [2:0] CMD_CLEAR_EOL  = 3'd5;

    // Characters the parser reacts to
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B; // '['
    localparam logic [7:0] CH_SEMI = 8'h3B; // ';'
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UP   = 8'h41; // 'A'
    localparam logic [7:0] CH_DOWN = 8'h42; // 'B'
    localparam logic [7:0] CH_FWD  = 8'h43; // 'C'
    localparam logic [7:0] CH_BACK = 8'h44; // 'D'
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_J    = 8'h4A;
    localparam logic [7:0] CH_K    = 8'h4B;

    // Output packing on tdata
    localparam int unsigned OUT_DATA_BITS = 48;

    // One parser step result
    typedef struct packed {
        logic               valid;
        logic [2:0]         command;
        logic [7:0]         char_code;
        logic signed [16:0] x_value;
        logic signed [16:0] y_value;
    } t_result;

endpackage

// ===== hdl/acp_core.sv =====
// Parser state and the per-byte decode of the escape sequence command parser.
module acp_core
    import acp_pkg::*;
#(
    parameter int unsigned PARAM_BITS = PARAM_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,   // consume i_byte this cycle
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    localparam int unsigned WIDE_BITS = (PARAM_BITS > 17) ? PARAM_BITS : 17;
    localparam int unsigned ACC_BITS  = PARAM_BITS + 4;
    localparam logic [PARAM_BITS-1:0] PARAM_MAX = {PARAM_BITS{1'b1}};
    localparam logic [PARAM_BITS-1:0] PARAM_ONE = PARAM_BITS'(1);
    localparam logic [PARAM_BITS-1:0] PARAM_TWO = PARAM_BITS'(2);

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_ESC   = 2'd1,
        PH_CSI   = 2'd2
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [PARAM_BITS-1:0] r_first, n_first;
    logic [PARAM_BITS-1:0] r_second, n_second;
    logic                  r_sel, n_sel;

    logic [PARAM_BITS-1:0] sel_val;
    logic [PARAM_BITS-1:0] sel_fix;
    logic [PARAM_BITS-1:0] first_eff;
    logic [PARAM_BITS-1:0] second_h;
    logic [7:0]            digit_diff;
    logic [ACC_BITS-1:0]   acc_sum;
    logic [PARAM_BITS-1:0] acc_sat;
    logic [WIDE_BITS-1:0]  first_w;
    logic [WIDE_BITS-1:0]  second_w;
    logic signed [16:0]    first17;
    logic signed [16:0]    second17;

    // Parameter fix-ups and decimal accumulation
    always_comb begin
        sel_val    = r_sel ? r_second : r_first;
        sel_fix    = (sel_val == '0) ? PARAM_ONE : sel_val;
        first_eff  = r_sel ? r_first : sel_fix;
        second_h   = (r_second == '0) ? PARAM_ONE : r_second;
        digit_diff = i_byte - CH_0;
        // x*10 + digit as two shifts and adds
        acc_sum    = (ACC_BITS'(sel_val) << 3) + (ACC_BITS'(sel_val) << 1)
                   + ACC_BITS'(digit_diff[3:0]);
        acc_sat    = (acc_sum > ACC_BITS'(PARAM_MAX)) ? PARAM_MAX
                                                      : acc_sum[PARAM_BITS-1:0];
        first_w    = WIDE_BITS'(first_eff);
        second_w   = WIDE_BITS'(second_h);
        first17    = first_w[16:0];
        second17   = second_w[16:0];
    end

    // Next state and result for the current byte
    always_comb begin
        n_phase  = r_phase;
        n_first  = r_first;
        n_second = r_second;
        n_sel    = r_sel;
        o_res    = '0;
        case (r_phase)
            PH_ESC: begin
                if (i_byte == CH_LBR) begin
                    n_phase = PH_CSI;
                end else begin
                    n_phase         = PH_PLAIN;
                    o_res.valid     = 1'b1;
                    o_res.command   = CMD_PUT_CHAR;
                    o_res.char_code = i_byte;
                end
            end
            PH_CSI: begin
                if (i_byte inside {[CH_0:CH_9]}) begin
                    if (r_sel) n_second = acc_sat;
                    else       n_first  = acc_sat;
                end else begin
                    if (r_sel) n_second = sel_fix;
                    else       n_first  = sel_fix;
                    n_phase = PH_PLAIN;
                    if (i_byte == CH_SEMI) begin
                        if (!r_sel) begin
                            n_sel   = 1'b1;
                            n_phase = PH_CSI;
                        end
                    end else begin
                        o_res.valid = 1'b1;
                        case (i_byte)
                            CH_H: begin
                                n_second      = second_h;
                                o_res.command = CMD_SET_CURSOR;
                                o_res.x_value = second17 - 17'sd1;
                                o_res.y_value = first17 - 17'sd1;
                            end
                            CH_UP: begin
                                o_res.command = CMD_MOVE;
                                o_res.y_value = -first17;
                            end
                            CH_DOWN: begin
                                o_res.command = CMD_MOVE;
                                o_res.y_value = first17;
                            end
                            CH_FWD: begin
                                o_res.command = CMD_MOVE;
                                o_res.x_value = first17;
                            end
                            CH_BACK: begin
                                o_res.command = CMD_MOVE;
                                o_res.x_value = -first17;
                            end
                            CH_J: begin
                                if (first_eff == PARAM_TWO) begin
                                    o_res.command = CMD_CLEAR_HOME;
                                end else if (first_eff == PARAM_ONE) begin
                                    o_res.command = CMD_CLEAR_EOS;
                                end else begin
                                    o_res.valid = 1'b0;
                                end
                            end
                            CH_K: begin
                                o_res.command = CMD_CLEAR_EOL;
                            end
                            default: begin
                                o_res.command   = CMD_PUT_CHAR;
                                o_res.char_code = i_byte;
                            end
                        endcase
                    end
                end
            end
            default: begin
                // plain text; the unused code behaves the same
                n_phase = PH_PLAIN;
                if (i_byte == CH_ESC) begin
                    n_phase  = PH_ESC;
                    n_first  = '0;
                    n_second = '0;
                    n_sel    = 1'b0;
                end else begin
                    o_res.valid     = 1'b1;
                    o_res.command   = CMD_PUT_CHAR;
                    o_res.char_code = i_byte;
                end
            end
        endcase
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PLAIN;
            r_first  <= '0;
            r_second <= '0;
            r_sel    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
            r_sel    <= n_sel;
        end
    end

endmodule

// ===== hdl/ansi_escape_command_parser.sv =====
// Top level of the escape sequence command parser: stream ports and registers.
// Takes one console byte per request and turns plain text and ESC[ sequences
// into display commands (put char, set cursor, move, clear and home, clear to
// end of screen, clear to end of line), at most one command per byte. A byte
// is taken every cycle while the result side keeps up; each byte passes an
// input register and the decode, and its command is then written into the
// result register when that register is free or emptying. The rate is one
// byte per cycle while the result side keeps up, as the parser state updates per byte.
// Bytes that end in no command (ESC, '[', digits, ';', unknown J) produce
// nothing on the output.
module ansi_escape_command_parser
    import acp_pkg::*;
#(
    parameter int unsigned PARAM_BITS = PARAM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] byte_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] command, [10:3] char_code, [27:11] x_value, [44:28] y_value,
    // [47:45] zero
    output logic [OUT_DATA_BITS-1:0] o_m_tdata
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    logic [2:0]         r_command;
    logic [7:0]         r_char_code;
    logic signed [16:0] r_x_value;
    logic signed [16:0] r_y_value;

    logic    advance;
    logic    in_take;
    t_result step_res;

    // Handshake: decode moves on when the result register is free or emptying
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    acp_core #(
        .PARAM_BITS(PARAM_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_res   (step_res)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;

            if (advance) r_out_valid <= step_res.valid;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_tdata;
        end
        if (advance && step_res.valid) begin
            r_command   <= step_res.command;
            r_char_code <= step_res.char_code;
            r_x_value   <= step_res.x_value;
            r_y_value   <= step_res.y_value;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_y_value, r_x_value, r_char_code, r_command};

endmodule

// ===== hdl/acp_checker.sv =====
// Port-level assertions for the escape sequence command parser, bound to the top.
`include "ansi_escape_command_parser_macros.svh"

module acp_checker
    import acp_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_tvalid,
    input logic                     o_s_tready,
    input logic [7:0]               i_s_tdata,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [OUT_DATA_BITS-1:0] o_m_tdata
);

    // Stalled result holds
    `ACP_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result changed under stall")

    // Reset empties the result register
    `ACP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

    // Only defined command codes, padding zero
    `ACP_ASSERT(a_cmd_range, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata[2:0] <= CMD_CLEAR_EOL && o_m_tdata[47:45] == 3'b000, "bad command or padding")

    // Character only on put char; put char carries no coordinates
    `ACP_ASSERT(a_char_field, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[2:0] == CMD_PUT_CHAR) ? (o_m_tdata[44:11] == '0) : (o_m_tdata[10:3] == 8'h00), "field not zero for command")

endmodule

bind ansi_escape_command_parser acp_checker u_acp_checker (.*);
